// File: rtl/patterned_rect_fill_page_buffer_unit_macros.svh
// Assertion macros shared by the checker.
`ifndef PATTERNED_RECT_FILL_PAGE_BUFFER_UNIT_MACROS_SVH
`define PATTERNED_RECT_FILL_PAGE_BUFFER_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define PRFPB_ASSERT_NOW(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("prfpb assertion failed");

// next-cycle implication, disabled in reset
`define PRFPB_ASSERT_NEXT(name, clk_s, rst_s, ante, cons) \
    name: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("prfpb assertion failed");

`endif

// File: rtl/prfpb_pkg.sv
`timescale 1ns / 1ps

package prfpb_pkg;

    localparam int STORE_DEPTH          = 1024;
    localparam int ADDR_W               = 10;
    // wide enough for page * width + column at the default screen size
    localparam int IDX_W                = 12;
    localparam int SCREEN_WIDTH_DEFAULT  = 128;
    localparam int SCREEN_HEIGHT_DEFAULT = 64;

    typedef enum logic {
        MODE_FILL = 1'b0,
        MODE_READ = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic        [7:0]  rect_width;
        logic signed [7:0]  rect_height;
        logic        [7:0]  pattern_byte0;
        logic        [7:0]  pattern_byte1;
        logic        [7:0]  pattern_byte2;
        logic        [7:0]  pattern_byte3;
        logic        [9:0]  read_address;
    } in_word_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       anything_drawn;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP,
        ST_SWEEP,
        ST_FLUSH,
        ST_READ,
        ST_RESPOND
    } state_t;

    typedef struct packed {
        logic load;
        logic clear;
        logic setup;
        logic step;
        logic rd_issue;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic clip_ok;
        logic sweep_last;
    } status_t;

endpackage

// File: rtl/patterned_rect_fill_page_buffer_unit.sv
`timescale 1ns / 1ps
// channel   ports                 handshake
// -------   --------------------  ------------------------------------------
// item in   item (in_word_t)      taken at edge with start high, busy low
// result    result (out_word_t)   valid for the one cycle done is high
//
// Read, or a fill clipped to nothing: ST_READ or ST_SETUP, then done in ST_RESPOND.
// Fill: ST_SETUP, then ST_SWEEP over the N frame bytes the clipped rectangle covers
// (up to 1024 at the default screen), ST_FLUSH and done in ST_RESPOND; one pipelined
// read-modify-write per cycle over the store's one read and one write port.
// After reset the store is cleared one byte a cycle; busy stays high until all are cleared.
// The next word can be taken from the cycle after done; the receiver cannot stall.

module patterned_rect_fill_page_buffer_unit
#(
    parameter int SCREEN_WIDTH  = prfpb_pkg::SCREEN_WIDTH_DEFAULT,
    parameter int SCREEN_HEIGHT = prfpb_pkg::SCREEN_HEIGHT_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  prfpb_pkg::in_word_t  item,
    output logic                 done,
    output prfpb_pkg::out_word_t result
);

    prfpb_pkg::cmd_t    cmd;
    prfpb_pkg::status_t stat;

    prfpb_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .start_mode (item.mode),
        .stat       (stat),
        .cmd        (cmd),
        .busy       (busy),
        .done       (done)
    );

    prfpb_dp
    #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    )
    u_dp
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule

// File: rtl/prfpb_ctrl.sv
`timescale 1ns / 1ps

module prfpb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  prfpb_pkg::mode_t   start_mode,
    input  prfpb_pkg::status_t stat,
    output prfpb_pkg::cmd_t    cmd,
    output logic               busy,
    output logic               done
);

    prfpb_pkg::state_t state_reg;
    prfpb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= prfpb_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prfpb_pkg::ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = prfpb_pkg::ST_IDLE;
                end
            end
            prfpb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (start_mode == prfpb_pkg::MODE_READ) ?
                                 prfpb_pkg::ST_READ : prfpb_pkg::ST_SETUP;
                end
            end
            prfpb_pkg::ST_SETUP:
            begin
                state_next = stat.clip_ok ? prfpb_pkg::ST_SWEEP : prfpb_pkg::ST_RESPOND;
            end
            prfpb_pkg::ST_SWEEP:
            begin
                if (stat.sweep_last)
                begin
                    state_next = prfpb_pkg::ST_FLUSH;
                end
            end
            prfpb_pkg::ST_FLUSH:   state_next = prfpb_pkg::ST_RESPOND;
            prfpb_pkg::ST_READ:    state_next = prfpb_pkg::ST_RESPOND;
            prfpb_pkg::ST_RESPOND: state_next = prfpb_pkg::ST_IDLE;
            default:               state_next = prfpb_pkg::ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            prfpb_pkg::ST_CLEAR:   cmd.clear = 1'b1;
            prfpb_pkg::ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            prfpb_pkg::ST_SETUP:   cmd.setup = 1'b1;
            prfpb_pkg::ST_SWEEP:   cmd.step = 1'b1;
            prfpb_pkg::ST_FLUSH:   ;
            prfpb_pkg::ST_READ:    cmd.rd_issue = 1'b1;
            prfpb_pkg::ST_RESPOND: done = 1'b1;
            default:               ;
        endcase
    end

endmodule

// File: rtl/prfpb_dp.sv
`timescale 1ns / 1ps

module prfpb_dp
#(
    parameter int SCREEN_WIDTH  = prfpb_pkg::SCREEN_WIDTH_DEFAULT,
    parameter int SCREEN_HEIGHT = prfpb_pkg::SCREEN_HEIGHT_DEFAULT
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  prfpb_pkg::in_word_t  item,
    input  prfpb_pkg::cmd_t      cmd,
    output prfpb_pkg::status_t   stat,
    output prfpb_pkg::out_word_t result
);

    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int PAGE_W = (ROW_W > 3) ? ROW_W - 3 : 1;
    localparam int ADDR_W = prfpb_pkg::ADDR_W;
    localparam int IDX_W  = prfpb_pkg::IDX_W;
    localparam logic signed [17:0] SW_S = 18'(SCREEN_WIDTH);
    localparam logic signed [17:0] SH_S = 18'(SCREEN_HEIGHT);

    logic [7:0] mem [prfpb_pkg::STORE_DEPTH];
    logic [7:0] mem_q_reg;

    prfpb_pkg::in_word_t in_reg;

    logic [ADDR_W-1:0] clr_cnt_reg;

    // sweep state
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_first_reg;
    logic [COL_W-1:0]  col_last_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] page_first_reg;
    logic [PAGE_W-1:0] page_last_reg;
    logic [IDX_W-1:0]  base_reg;
    logic [7:0]        top_mask_reg;
    logic [7:0]        bot_mask_reg;
    logic              drawn_reg;

    // write-back stage
    logic              wr_v_reg;
    logic              wr_v_next;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic [7:0]        wr_mask_reg;
    logic [7:0]        wr_pat_reg;

    // clipping
    logic signed [17:0] x_s;
    logic signed [17:0] y_s;
    logic signed [17:0] right_s;
    logic signed [17:0] bottom_s;
    logic signed [17:0] right_cl;
    logic signed [17:0] bottom_cl;
    logic signed [17:0] col_last_s;
    logic signed [17:0] row_last_s;
    logic               ok_x;
    logic               ok_y;
    logic [COL_W-1:0]   left_c;
    logic [ROW_W-1:0]   top_r;
    logic [ROW_W-1:0]   row_last_r;
    logic [PAGE_W-1:0]  page_first_c;

    // sweep combinational
    logic [IDX_W-1:0]  idx;
    logic              in_range;
    logic [7:0]        cur_mask;
    logic [7:0]        cur_pat;
    logic              col_end;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;

    function automatic logic signed [17:0] item_sx(input logic signed [15:0] v);
        item_sx = {{2{v[15]}}, v};
    endfunction

    always_comb
    begin
        x_s      = 18'(item_sx(in_reg.rect_left));
        y_s      = 18'(item_sx(in_reg.rect_top));
        right_s  = x_s + $signed({10'd0, in_reg.rect_width});
        bottom_s = y_s + $signed({{10{in_reg.rect_height[7]}}, in_reg.rect_height});
        ok_x     = (in_reg.rect_width != 8'd0) && (x_s < SW_S) && (right_s > 18'sd0);
        ok_y     = !in_reg.rect_height[7] && (in_reg.rect_height != 8'sd0)
                   && (y_s < SH_S) && (bottom_s > 18'sd0);
        right_cl   = (right_s > SW_S) ? SW_S : right_s;
        bottom_cl  = (bottom_s > SH_S) ? SH_S : bottom_s;
        col_last_s = right_cl - 18'sd1;
        row_last_s = bottom_cl - 18'sd1;
        left_c     = x_s[17] ? '0 : x_s[COL_W-1:0];
        top_r      = y_s[17] ? '0 : y_s[ROW_W-1:0];
        row_last_r = row_last_s[ROW_W-1:0];
        page_first_c = PAGE_W'(top_r >> 3);
    end

    always_comb
    begin
        idx      = base_reg + IDX_W'(col_reg);
        in_range = idx < IDX_W'(prfpb_pkg::STORE_DEPTH);
        cur_mask = ((page_reg == page_first_reg) ? top_mask_reg : 8'hFF)
                   & ((page_reg == page_last_reg) ? bot_mask_reg : 8'hFF);
        case (col_reg[1:0])
            2'd0:    cur_pat = in_reg.pattern_byte0;
            2'd1:    cur_pat = in_reg.pattern_byte1;
            2'd2:    cur_pat = in_reg.pattern_byte2;
            default: cur_pat = in_reg.pattern_byte3;
        endcase
        col_end   = col_reg == col_last_reg;
        wr_v_next = cmd.step && in_range;
        rd_addr   = cmd.rd_issue ? in_reg.read_address : idx[ADDR_W-1:0];
        rd_en     = cmd.rd_issue || cmd.step;
        wr_en     = cmd.clear || wr_v_reg;
        wr_addr   = cmd.clear ? clr_cnt_reg : wr_addr_reg;
        wr_data   = cmd.clear ? 8'h00
                              : ((mem_q_reg & ~wr_mask_reg) | (wr_pat_reg & wr_mask_reg));
    end

    // one write port, one registered read port; a sweep never reads the
    // byte being written back in the same cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            wr_v_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end
            wr_v_reg <= wr_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= item;
        end
        if (cmd.setup)
        begin
            drawn_reg      <= ok_x && ok_y;
            col_reg        <= left_c;
            col_first_reg  <= left_c;
            col_last_reg   <= col_last_s[COL_W-1:0];
            page_reg       <= page_first_c;
            page_first_reg <= page_first_c;
            page_last_reg  <= PAGE_W'(row_last_r >> 3);
            base_reg       <= IDX_W'(page_first_c) * IDX_W'(SCREEN_WIDTH);
            top_mask_reg   <= 8'hFF << top_r[2:0];
            bot_mask_reg   <= 8'hFF >> (3'd7 - row_last_r[2:0]);
        end
        else if (cmd.step)
        begin
            if (col_end)
            begin
                col_reg  <= col_first_reg;
                page_reg <= page_reg + PAGE_W'(1);
                base_reg <= base_reg + IDX_W'(SCREEN_WIDTH);
            end
            else
            begin
                col_reg <= col_reg + COL_W'(1);
            end
        end
        wr_addr_reg <= idx[ADDR_W-1:0];
        wr_mask_reg <= cur_mask;
        wr_pat_reg  <= cur_pat;
    end

    always_comb
    begin
        stat.clear_last = clr_cnt_reg == ADDR_W'(prfpb_pkg::STORE_DEPTH - 1);
        stat.clip_ok    = ok_x && ok_y;
        stat.sweep_last = col_end && (page_reg == page_last_reg);
        if (in_reg.mode == prfpb_pkg::MODE_READ)
        begin
            result.read_data      = mem_q_reg;
            result.anything_drawn = 1'b0;
        end
        else
        begin
            result.read_data      = 8'h00;
            result.anything_drawn = drawn_reg;
        end
    end

endmodule

// File: rtl/prfpb_chk.sv
`timescale 1ns / 1ps
`include "patterned_rect_fill_page_buffer_unit_macros.svh"

module prfpb_chk
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 start,
    input logic                 busy,
    input prfpb_pkg::in_word_t  item,
    input logic                 done,
    input prfpb_pkg::out_word_t result
);

    logic accept;
    logic read_accept;
    assign accept      = start && !busy;
    assign read_accept = accept && (item.mode == prfpb_pkg::MODE_READ);

    `PRFPB_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
    `PRFPB_ASSERT_NEXT(a_read_latency, clk, rst_n, read_accept, !done ##1 done)
    `PRFPB_ASSERT_NOW(a_done_while_busy, clk, rst_n, done, busy)
    `PRFPB_ASSERT_NEXT(a_idle_after_done, clk, rst_n, done, !busy && !done)
    `PRFPB_ASSERT_NOW(a_one_field_only, clk, rst_n, done, !(result.anything_drawn && |result.read_data))

endmodule

bind patterned_rect_fill_page_buffer_unit prfpb_chk u_prfpb_chk
(
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .done   (done),
    .result (result)
);
